### design/bcra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bitmap contiguous run allocator.
package bcra_pkg;

	localparam int MAP_BYTES_DEF = 64;
	localparam int BITS_PER_BYTE = 8;

	localparam int OP_W  = 2;
	localparam int IDX_W = 9;
	localparam int LEN_W = 10;
	localparam int CFG_W = 7;
	localparam int EFF_W = CFG_W + 1;
	localparam int RUN_W = 10;
	localparam int BIT_W = 10;

	// bytes_in_use can never name a byte at or above this
	localparam int ADDRESSABLE_BYTES = 2 ** CFG_W;

	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_BYTES_IN_USE = 2'd0;
	localparam logic [CFG_W-1:0] BYTES_IN_USE_RST = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_TEST  = 2'd1,
		OP_SCAN  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RMW,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic clear_all;
		logic item_rd;
		logic test_eval;
		logic wr_item;
		logic scan_rd;
		logic scan_eval;
		logic push;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic in_range;
		logic eff_zero;
		logic hit;
		logic scan_done;
	} sts_t;

endpackage

### design/bcra_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the bitmap allocator: sequences each word.
module bcra_ctrl
	import bcra_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	output logic result_valid,
	input  logic result_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid)
					state_n = S_DECODE;
			end
			S_DECODE: begin
				case (sts.op) inside
					OP_TEST, OP_WRITE: state_n = sts.in_range ? S_RMW : S_RESP;
					OP_SCAN:           state_n = sts.eff_zero ? S_RESP : S_SCAN;
					default:           state_n = S_RESP;
				endcase
			end
			S_RMW: state_n = S_RESP;
			S_SCAN: begin
				if (sts.hit || sts.scan_done)
					state_n = S_RESP;
			end
			S_RESP: begin
				if (out_free)
					state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = item_valid;
			S_DECODE: begin
				case (sts.op) inside
					OP_CLEAR:          cmd.clear_all = 1'b1;
					OP_TEST, OP_WRITE: cmd.item_rd = sts.in_range;
					OP_SCAN:           cmd.scan_rd = !sts.eff_zero;
					default:           cmd.clear_all = 1'b0;
				endcase
			end
			S_RMW: begin
				cmd.test_eval = (sts.op == OP_TEST);
				cmd.wr_item   = (sts.op == OP_WRITE);
			end
			S_SCAN: begin
				cmd.scan_eval = 1'b1;
				cmd.scan_rd   = !sts.hit && !sts.scan_done;
			end
			S_RESP: cmd.push = out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### design/bcra_dp.sv
`timescale 1ns / 1ps
// Datapath of the bitmap allocator: map memory, scan logic and result registers.
module bcra_dp
	import bcra_pkg::*;
#(
	parameter int MAP_BYTES = MAP_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [CFG_W-1:0] bytes_in_use,
	input  logic [OP_W-1:0]  operation,
	input  logic [IDX_W-1:0] bit_index,
	input  logic             bit_value,
	input  logic [LEN_W-1:0] run_length,
	output logic             bit_is_set,
	output logic             found,
	output logic [IDX_W-1:0] start_index
);

	localparam int DEPTH = (MAP_BYTES < ADDRESSABLE_BYTES) ? MAP_BYTES : ADDRESSABLE_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BSEL_W = $clog2(BITS_PER_BYTE);

	logic [7:0]       mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;

	op_t              op_q;
	logic [IDX_W-1:0] pos_q;
	logic             val_q;
	logic [LEN_W-1:0] len_q;
	logic [RUN_W-1:0] run_q;
	logic [EFF_W-1:0] rd_cnt_q;
	logic [EFF_W-1:0] proc_q;
	logic [7:0]       rdata_q;
	logic             rvalid_q;
	logic             is_set_q, found_q;
	logic [IDX_W-1:0] start_q;
	logic             out_is_set_q, out_found_q;
	logic [IDX_W-1:0] out_start_q;

	logic [EFF_W-1:0] eff;
	logic [EFF_W-1:0] pos_byte;
	logic [AW-1:0]    item_addr;
	logic [AW-1:0]    raddr;
	logic             re;
	logic [7:0]       cur_byte;
	logic [7:0]       wdata;
	logic [RUN_W-1:0] run_n;
	logic             hit;
	logic [BSEL_W-1:0] hit_pos;
	logic [BIT_W-1:0] hit_bit;
	logic [BIT_W-1:0] start_full;

	assign eff = ({1'b0, bytes_in_use} > EFF_W'(DEPTH)) ? EFF_W'(DEPTH) : {1'b0, bytes_in_use};
	assign pos_byte  = EFF_W'(pos_q[IDX_W-1:BSEL_W]);
	assign item_addr = pos_byte[AW-1:0];
	assign cur_byte  = rvalid_q ? rdata_q : 8'h00;

	assign re    = cmd.item_rd || cmd.scan_rd;
	assign raddr = cmd.scan_rd ? rd_cnt_q[AW-1:0] : item_addr;

	always_comb begin
		wdata = cur_byte;
		wdata[pos_q[BSEL_W-1:0]] = val_q;
	end

	// eight bit steps of the run counter over one map byte
	always_comb begin
		run_n   = run_q;
		hit     = 1'b0;
		hit_pos = '0;
		for (int b = 0; b < BITS_PER_BYTE; b++) begin
			if (!hit) begin
				if (cur_byte[b]) begin
					run_n = '0;
				end else begin
					run_n = run_n + RUN_W'(1);
					if (run_n == len_q) begin
						hit     = 1'b1;
						hit_pos = BSEL_W'(b);
					end
				end
			end
		end
	end

	assign hit_bit    = {proc_q[BIT_W-BSEL_W-1:0], hit_pos};
	assign start_full = hit_bit + BIT_W'(1) - BIT_W'(len_q);

	assign sts.op        = op_q;
	assign sts.in_range  = (pos_byte < eff);
	assign sts.eff_zero  = (eff == '0);
	assign sts.hit       = hit;
	assign sts.scan_done = (rd_cnt_q == eff);

	always_ff @(posedge clk) begin
		if (cmd.wr_item)
			mem_q[item_addr] <= wdata;
		if (re) begin
			rdata_q  <= mem_q[raddr];
			rvalid_q <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clear_all) begin
			vld_q <= '0;
		end else if (cmd.wr_item) begin
			vld_q[item_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(operation);
			pos_q    <= bit_index;
			val_q    <= bit_value;
			len_q    <= run_length;
			run_q    <= '0;
			rd_cnt_q <= '0;
			is_set_q <= 1'b0;
			found_q  <= 1'b0;
			start_q  <= '0;
		end else begin
			if (cmd.scan_rd) begin
				rd_cnt_q <= rd_cnt_q + EFF_W'(1);
				proc_q   <= rd_cnt_q;
			end
			if (cmd.scan_eval) begin
				run_q <= run_n;
				if (hit) begin
					found_q <= 1'b1;
					start_q <= start_full[IDX_W-1:0];
				end
			end
			if (cmd.test_eval)
				is_set_q <= cur_byte[pos_q[BSEL_W-1:0]];
		end
		if (cmd.push) begin
			out_is_set_q <= is_set_q;
			out_found_q  <= found_q;
			out_start_q  <= start_q;
		end
	end

	assign bit_is_set  = out_is_set_q;
	assign found       = out_found_q;
	assign start_index = out_start_q;

endmodule

### design/bitmap_contiguous_run_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the bitmap first-fit contiguous run allocator.
//
// Input channel (item_valid/item_stall) carries one operation word: clear all,
// test bit, scan for a free run of run_length zero bits, or write bit.
// Result channel (result_valid/result_stall) returns one word per input word:
// bit_is_set for test, found and start_index for scan, zeros otherwise.
// The APB port holds bytes_in_use at address 0; write it only while idle.
// One word is worked at a time; the next is taken in the cycle after the result
// is loaded. From accept, each word passes DECODE and then RESP; test and
// write pass RMW between them when the index is in range, and a scan passes
// SCAN over bytes in use (capped at MAP_BYTES), stopping early when a run is
// found, or goes straight to RESP when no bytes are in use.
// The scan reads the map memory one byte per cycle through its single read
// port; that port sets the scan time.
// A finished result waits in the output register while result_stall is high,
// and the next word is still accepted; its result waits until the slot frees.
// Reset empties the map (every bit free), sets bytes_in_use to 64 and drops
// any pending result.
module bitmap_contiguous_run_allocator_top
	import bcra_pkg::*;
#(
	parameter int MAP_BYTES = MAP_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [IDX_W-1:0]  bit_index,
	input  logic              bit_value,
	input  logic [LEN_W-1:0]  run_length,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              bit_is_set,
	output logic              found,
	output logic [IDX_W-1:0]  start_index
);

	logic [CFG_W-1:0] bytes_in_use_q;
	cmd_t             cmd;
	sts_t             sts;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_BYTES_IN_USE) ? APB_DW'(bytes_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_in_use_q <= BYTES_IN_USE_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_BYTES_IN_USE) begin
			bytes_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	bcra_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	bcra_dp #(
		.MAP_BYTES (MAP_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.bytes_in_use (bytes_in_use_q),
		.operation    (operation),
		.bit_index    (bit_index),
		.bit_value    (bit_value),
		.run_length   (run_length),
		.bit_is_set   (bit_is_set),
		.found        (found),
		.start_index  (start_index)
	);

endmodule

### test/bitmap_contiguous_run_allocator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap first-fit contiguous run allocator.
module bitmap_contiguous_run_allocator_top_tb;
	import bcra_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int PHASES = 7;
	localparam int PHASE_WORDS = 265;
	localparam int PHASE_CFG [PHASES] = '{64, 127, 1, 0, 23, 64, 40};
	localparam int PHASE_FILL [PHASES] = '{50, 85, 50, 50, 30, 15, 70};
	localparam int QUIET_PHASE = 1;

	typedef struct packed {
		logic             bit_is_set;
		logic             found;
		logic [IDX_W-1:0] start_index;
	} result_t;

	typedef struct packed {
		logic             is_cfg;
		logic [CFG_W-1:0] cfg;
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic             val;
		logic [LEN_W-1:0] len;
		logic             known;
		logic             e_set;
		logic             e_found;
		logic [IDX_W-1:0] e_start;
	} row_t;

	// cfg rows: is_cfg, value; word rows: op, index, value, length, known, expected set/found/start
	localparam int PLAN_ROWS = 29;
	localparam row_t PLAN [PLAN_ROWS] = '{
		'{1'b0, 7'd0,   OP_TEST,  9'd0,   1'b0, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd512,  1'b1, 1'b0, 1'b1, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd513,  1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_WRITE, 9'd0,   1'b1, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_TEST,  9'd0,   1'b0, 10'd0,    1'b1, 1'b1, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd1,    1'b1, 1'b0, 1'b1, 9'd1},
		'{1'b0, 7'd0,   OP_WRITE, 9'd511, 1'b1, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_TEST,  9'd511, 1'b0, 10'd0,    1'b1, 1'b1, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd511,  1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd510,  1'b1, 1'b0, 1'b1, 9'd1},
		'{1'b0, 7'd0,   OP_WRITE, 9'd3,   1'b1, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd4,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_CLEAR, 9'd0,   1'b0, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_TEST,  9'd511, 1'b0, 10'd1023, 1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b1, 7'd0,   OP_CLEAR, 9'd0,   1'b0, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd1,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_WRITE, 9'd5,   1'b1, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_TEST,  9'd5,   1'b0, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b1, 7'd127, OP_CLEAR, 9'd0,   1'b0, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_TEST,  9'd5,   1'b0, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd512,  1'b1, 1'b0, 1'b1, 9'd0},
		'{1'b1, 7'd1,   OP_CLEAR, 9'd0,   1'b0, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_WRITE, 9'd8,   1'b1, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_WRITE, 9'd2,   1'b1, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd6,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_SCAN,  9'd0,   1'b0, 10'd5,    1'b0, 1'b0, 1'b0, 9'd0},
		'{1'b0, 7'd0,   OP_TEST,  9'd8,   1'b0, 10'd0,    1'b1, 1'b0, 1'b0, 9'd0},
		'{1'b1, 7'd64,  OP_CLEAR, 9'd0,   1'b0, 10'd0,    1'b0, 1'b0, 1'b0, 9'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [OP_W-1:0]   operation = '0;
	logic [IDX_W-1:0]  bit_index = '0;
	logic              bit_value = 1'b0;
	logic [LEN_W-1:0]  run_length = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              bit_is_set;
	logic              found;
	logic [IDX_W-1:0]  start_index;

	logic [7:0]        marks [MAP_BYTES_DEF] = '{default: 8'h00};
	logic [CFG_W-1:0]  bytes_reg = BYTES_IN_USE_RST;
	result_t           responses_due [$];
	int                mismatches = 0;
	int                cycles = 0;
	bit                quiet = 1'b0;

	bitmap_contiguous_run_allocator_top DUT (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic flag(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	function automatic int active_bits();
		return (bytes_reg > MAP_BYTES_DEF ? MAP_BYTES_DEF : int'(bytes_reg)) * BITS_PER_BYTE;
	endfunction

	// response of one word, updating the mark map
	function automatic result_t compute_response(input op_t op, input logic [IDX_W-1:0] idx,
			input logic val, input logic [LEN_W-1:0] len);
		result_t r;
		int total;
		int run;
		r = '0;
		total = active_bits();
		run = 0;
		case (op)
			OP_CLEAR: begin
				foreach (marks[b])
					marks[b] = 8'h00;
			end
			OP_TEST: begin
				if (idx < total)
					r.bit_is_set = marks[idx[8:3]][idx[2:0]];
			end
			OP_SCAN: begin
				if (len != 0 && len <= total)
					for (int i = 0; i < total && !r.found; i++) begin
						if (marks[i / 8][i % 8]) begin
							run = 0;
						end else begin
							run++;
							if (run == len) begin
								r.found = 1'b1;
								r.start_index = IDX_W'(i + 1 - len);
							end
						end
					end
			end
			OP_WRITE: begin
				if (idx < total)
					marks[idx[8:3]][idx[2:0]] = val;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (responses_due.size() == 0) begin
				flag("result word with none pending", 0, 1);
			end else begin
				want = responses_due.pop_front();
				if (bit_is_set !== want.bit_is_set)
					flag("bit_is_set", int'(want.bit_is_set), int'(bit_is_set));
				if (found !== want.found)
					flag("found", int'(want.found), int'(found));
				if (start_index !== want.start_index)
					flag("start_index", int'(want.start_index), int'(start_index));
			end
		end
		result_stall <= !quiet && ($urandom_range(99) < 21);
	end

	task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx, input logic val,
			input logic [LEN_W-1:0] len, input logic known, input result_t given);
		result_t r;
		while (!quiet && $urandom_range(99) < 21) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		bit_index <= idx;
		bit_value <= val;
		run_length <= len;
		do @(posedge clk); while (item_stall);
		r = compute_response(op, idx, val, len);
		responses_due.push_back(known ? given : r);
	endtask

	task automatic random_word(input int fill_pct);
		int total;
		int pick;
		op_t op;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		logic val;
		total = active_bits();
		pick = $urandom_range(99);
		op = pick < 1 ? OP_CLEAR : pick < 27 ? OP_TEST : pick < 55 ? OP_SCAN : OP_WRITE;
		pick = $urandom_range(99);
		if (total != 0 && pick < 50)
			idx = IDX_W'($urandom_range((total > 64 ? 64 : total) - 1));
		else if (total != 0 && pick < 85)
			idx = IDX_W'($urandom_range(total - 1));
		else
			idx = IDX_W'($urandom_range(511));
		val = $urandom_range(99) < fill_pct;
		pick = $urandom_range(99);
		if (pick < 60)
			len = LEN_W'($urandom_range(12, 1));
		else if (pick < 85)
			len = LEN_W'($urandom_range(total + 2, 1));
		else
			len = LEN_W'($urandom_range(1023));
		send_word(op, idx, val, len, 1'b0, '0);
	endtask

	// drain every pending word before touching the register
	task automatic settle();
		item_valid <= 1'b0;
		while (responses_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_bytes_in_use(input logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_BYTES_IN_USE;
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		bytes_reg = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DW'(v))
			flag("bytes_in_use readback", int'(v), int'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (PLAN[r]) begin
			if (PLAN[r].is_cfg) begin
				settle();
				set_bytes_in_use(PLAN[r].cfg);
			end else begin
				send_word(PLAN[r].op, PLAN[r].idx, PLAN[r].val, PLAN[r].len, PLAN[r].known,
					{PLAN[r].e_set, PLAN[r].e_found, PLAN[r].e_start});
			end
		end
		for (int p = 0; p < PHASES; p++) begin
			settle();
			quiet = (p == QUIET_PHASE);
			set_bytes_in_use(CFG_W'(PHASE_CFG[p]));
			for (int n = 0; n < PHASE_WORDS; n++)
				random_word(PHASE_FILL[p]);
		end
		item_valid <= 1'b0;
		quiet = 1'b0;
		while (responses_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
